>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WTM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wtm checker: same-cycle property failed");

// next-cycle implication
`define WTM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wtm checker: next-cycle property failed");

`endif

>>> hdl/wtm_pkg.sv
// Shared types, constants and helpers of the windowed throughput meter.
// No dependencies.
package wtm_pkg;

    localparam int TIME_BITS_DEF = 48;
    localparam int BYTES_W       = 32;
    localparam int STAMP_W       = 48;
    localparam int RATE_W        = 40;
    localparam int CFG_W         = 16;
    localparam int WIN_BYTES_W   = 40;
    localparam int TOT_BYTES_W   = 48;
    localparam int PROD_W        = 56;
    localparam int ZERO_ELAPSED_MS = 1000;

    typedef logic [BYTES_W-1:0]     bytes_t;
    typedef logic [STAMP_W-1:0]     stamp_t;
    typedef logic [RATE_W-1:0]      rate_t;
    typedef logic [CFG_W-1:0]       cfg_data_t;
    typedef logic [0:0]             cfg_index_t;
    typedef logic [WIN_BYTES_W-1:0] win_bytes_t;
    typedef logic [TOT_BYTES_W-1:0] tot_bytes_t;
    typedef logic [PROD_W-1:0]      prod_t;

    localparam cfg_index_t CFG_WINDOW_MS = 1'd0;
    localparam cfg_index_t CFG_SETTLE_MS = 1'd1;

    localparam cfg_data_t WINDOW_MS_RESET = 16'd1000;
    localparam cfg_data_t SETTLE_MS_RESET = 16'd500;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef struct packed {
        logic capture;
        logic update;
        logic prep;
        logic div_start;
        logic load_out;
    } wtm_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic div_busy;
        logic out_free;
    } wtm_sts_t;

    // bytes * 250 as shifts: 256 - 4 - 2
    function automatic prod_t times_250(input prod_t b);
        prod_t r;
        r = (b << 8) - (b << 2) - (b << 1);
        return r;
    endfunction

    function automatic rate_t sat_rate(input prod_t q);
        rate_t r;
        r = (q[PROD_W-1:RATE_W] != '0) ? '1 : q[RATE_W-1:0];
        return r;
    endfunction

endpackage

>>> hdl/wtm_in_if.sv
// Input channel of the meter: valid/ready plus one item.
// Depends on wtm_pkg.
interface wtm_in_if
    import wtm_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   action;
    bytes_t byte_count;
    stamp_t now_ms;

    modport source (output valid, output action, output byte_count, output now_ms,
                    input ready);
    modport sink   (input valid, input action, input byte_count, input now_ms,
                    output ready);
endinterface

>>> hdl/wtm_out_if.sv
// Output channel of the meter: valid/ready plus three rates.
// Depends on wtm_pkg.
interface wtm_out_if
    import wtm_pkg::*;
;
    logic  valid;
    logic  ready;
    rate_t current_rate;
    rate_t last_window_rate;
    rate_t average_rate;

    modport source (output valid, output current_rate, output last_window_rate,
                    output average_rate, input ready);
    modport sink   (input valid, input current_rate, input last_window_rate,
                    input average_rate, output ready);
endinterface

>>> hdl/wtm_div.sv
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// No dependencies; standalone.
module wtm_div #(
    parameter int DIVIDEND_W = 56,
    parameter int DIVISOR_W  = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  den_reg;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  take;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = shifted - {1'b0, den_reg};
        take      = (shifted >= {1'b0, den_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = take ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next  = {quo_reg[DIVIDEND_W-2:0], take};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule

>>> hdl/wtm_dp.sv
// Datapath: config registers, meter state, products, two dividers, result register.
// Depends on wtm_pkg and wtm_div.
module wtm_dp
    import wtm_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  wtm_cmd_t   cmd,
    output wtm_sts_t   sts,
    input  logic       cfg_we,
    input  cfg_index_t cfg_index,
    input  cfg_data_t  cfg_data,
    input  logic       action,
    input  bytes_t     byte_count,
    input  stamp_t     now_ms,
    output logic       out_valid,
    input  logic       out_ready,
    output rate_t      current_rate,
    output rate_t      last_window_rate,
    output rate_t      average_rate
);
    typedef logic [TIME_BITS-1:0] tm_t;

    cfg_data_t  window_ms_reg, settle_ms_reg;

    logic       act_reg;
    bytes_t     bytes_reg;
    tm_t        now_reg;

    logic       started_reg;
    tm_t        first_time_reg, window_start_reg;
    tot_bytes_t total_bytes_reg;
    win_bytes_t window_bytes_reg, last_window_bytes_reg;

    prod_t      win_prod_reg, tot_prod_reg;
    tm_t        win_den_reg, tot_den_reg;
    logic       ge_settle_reg;

    logic       out_valid_reg, out_valid_next;
    rate_t      cur_reg, last_reg, avg_reg;

    logic [TIME_BITS+STAMP_W-1:0] now_wide;
    logic [WIN_BYTES_W:0]         win_sum;
    logic [TOT_BYTES_W:0]         tot_sum;
    win_bytes_t                   win_sat;
    tot_bytes_t                   tot_sat;
    tm_t                          since_start, win_el, tot_el;
    logic                         in_window;
    prod_t                        win_q, tot_q;
    logic                         win_busy, tot_busy;
    rate_t                        cur_rate;

    assign now_wide    = {{TIME_BITS{1'b0}}, now_ms};
    assign win_sum     = {1'b0, window_bytes_reg} + (WIN_BYTES_W+1)'(bytes_reg);
    assign tot_sum     = {1'b0, total_bytes_reg} + (TOT_BYTES_W+1)'(bytes_reg);
    assign win_sat     = win_sum[WIN_BYTES_W] ? '1 : win_sum[WIN_BYTES_W-1:0];
    assign tot_sat     = tot_sum[TOT_BYTES_W] ? '1 : tot_sum[TOT_BYTES_W-1:0];
    assign since_start = now_reg - window_start_reg;
    assign in_window   = (since_start < TIME_BITS'(window_ms_reg));
    assign win_el      = now_reg - window_start_reg;
    assign tot_el      = now_reg - first_time_reg;

    // config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ms_reg <= WINDOW_MS_RESET;
            settle_ms_reg <= SETTLE_MS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW_MS: window_ms_reg <= cfg_data;
                CFG_SETTLE_MS: settle_ms_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg   <= action;
            bytes_reg <= byte_count;
            now_reg   <= now_wide[TIME_BITS-1:0];
        end
    end

    // meter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg           <= 1'b0;
            first_time_reg        <= '0;
            window_start_reg      <= '0;
            total_bytes_reg       <= '0;
            window_bytes_reg      <= '0;
            last_window_bytes_reg <= '0;
        end
        else if (cmd.update)
        begin
            if (act_reg == ACT_CLEAR)
            begin
                started_reg           <= 1'b0;
                first_time_reg        <= '0;
                window_start_reg      <= '0;
                total_bytes_reg       <= '0;
                window_bytes_reg      <= '0;
                last_window_bytes_reg <= '0;
            end
            else if (!started_reg)
            begin
                started_reg      <= 1'b1;
                first_time_reg   <= now_reg;
                window_start_reg <= now_reg;
                window_bytes_reg <= win_sat;
                total_bytes_reg  <= tot_sat;
            end
            else if (in_window)
            begin
                window_bytes_reg <= win_sat;
                total_bytes_reg  <= tot_sat;
            end
            else
            begin
                last_window_bytes_reg <= window_bytes_reg;
                window_bytes_reg      <= WIN_BYTES_W'(bytes_reg);
                total_bytes_reg       <= tot_sat;
                window_start_reg      <= now_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            win_prod_reg  <= times_250(PROD_W'(window_bytes_reg));
            tot_prod_reg  <= times_250(PROD_W'(total_bytes_reg));
            win_den_reg   <= (win_el == '0) ? TIME_BITS'(ZERO_ELAPSED_MS) : win_el;
            tot_den_reg   <= (tot_el == '0) ? TIME_BITS'(ZERO_ELAPSED_MS) : tot_el;
            ge_settle_reg <= (win_el >= TIME_BITS'(settle_ms_reg));
        end
    end

    wtm_div #(.DIVIDEND_W(PROD_W), .DIVISOR_W(TIME_BITS)) u_div_win (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (win_prod_reg),
        .divisor  (win_den_reg),
        .busy     (win_busy),
        .quotient (win_q)
    );

    wtm_div #(.DIVIDEND_W(PROD_W), .DIVISOR_W(TIME_BITS)) u_div_tot (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (tot_prod_reg),
        .divisor  (tot_den_reg),
        .busy     (tot_busy),
        .quotient (tot_q)
    );

    assign cur_rate = sat_rate(win_q);

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (act_reg == ACT_CLEAR)
            begin
                cur_reg  <= '0;
                last_reg <= '0;
                avg_reg  <= '0;
            end
            else
            begin
                cur_reg <= cur_rate;
                avg_reg <= sat_rate(tot_q);
                if (last_window_bytes_reg != '0)
                begin
                    last_reg <= RATE_W'(last_window_bytes_reg >> 2);
                end
                else
                begin
                    last_reg <= ge_settle_reg ? cur_rate : '0;
                end
            end
        end
    end

    assign sts.is_clear     = (act_reg == ACT_CLEAR);
    assign sts.div_busy     = win_busy | tot_busy;
    assign sts.out_free     = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign current_rate     = cur_reg;
    assign last_window_rate = last_reg;
    assign average_rate     = avg_reg;
endmodule

>>> hdl/wtm_ctrl.sv
// Controller: per item, sequences capture, update, divide if add, result load.
// Depends on wtm_pkg.
module wtm_ctrl
    import wtm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  wtm_sts_t sts,
    output wtm_cmd_t cmd
);
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_UPDATE = 6'b000010,
        ST_PREP   = 6'b000100,
        ST_START  = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = sts.is_clear ? ST_DONE : ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_START;
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

>>> hdl/windowed_throughput_meter_top.sv
// Windowed throughput meter: takes one item at a time and returns three rates
// in 1/250 KB/s. An add item is captured, updates the meter state, prepares the
// products and divisors and starts the two bit-serial dividers (window and
// overall rate), which work side by side; once both are done the result is
// loaded into the result register as soon as that register is free. A clear
// item skips the products and the divide. The next item is taken as soon as
// the result is loaded, even while it still waits in the output register.
// Depends on wtm_pkg, wtm_in_if, wtm_out_if, wtm_ctrl, wtm_dp.
module windowed_throughput_meter_top
    import wtm_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    wtm_in_if.sink     item,
    wtm_out_if.source  report,
    input  logic       cfg_we,
    input  cfg_index_t cfg_index,
    input  cfg_data_t  cfg_data
);
    wtm_cmd_t cmd;
    wtm_sts_t sts;

    wtm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wtm_dp #(.TIME_BITS(TIME_BITS)) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .action           (item.action),
        .byte_count       (item.byte_count),
        .now_ms           (item.now_ms),
        .out_valid        (report.valid),
        .out_ready        (report.ready),
        .current_rate     (report.current_rate),
        .last_window_rate (report.last_window_rate),
        .average_rate     (report.average_rate)
    );
endmodule

>>> hdl/wtm_checker.sv
// Port-level checker for the meter, bound to the top level.
// Depends on wtm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wtm_checker
    import wtm_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input logic  out_valid,
    input logic  out_ready,
    input rate_t current_rate,
    input rate_t last_window_rate,
    input rate_t average_rate
);
    logic [3*RATE_W-1:0] rates_all;

    assign rates_all = {current_rate, last_window_rate, average_rate};

    `WTM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
    `WTM_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(rates_all))
    `WTM_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
    `WTM_ASSERT_IMP(a_result_while_busy, $rose(out_valid), !$past(in_ready))
endmodule

bind windowed_throughput_meter_top wtm_checker u_wtm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (item.valid),
    .in_ready         (item.ready),
    .out_valid        (report.valid),
    .out_ready        (report.ready),
    .current_rate     (report.current_rate),
    .last_window_rate (report.last_window_rate),
    .average_rate     (report.average_rate)
);
